[design/rhw_pkg.sv]
`default_nettype none

package rhw_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_HALT
  } phase_t;

  typedef enum logic [3:0] {
    EV_NONE,
    EV_DONE_HEAD,
    EV_EOS,
    EV_SKIP_BYTE,
    EV_SKIP_END,
    EV_SKIP_DONE,
    EV_HDR_BYTE,
    EV_BAD_MAGIC,
    EV_BAD_INDEX,
    EV_BAD_CRC,
    EV_NEG_ROWS,
    EV_OK
  } event_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_DONE       = 3'd1;
  localparam logic [2:0] ST_SHORT_HDR  = 3'd2;
  localparam logic [2:0] ST_MAGIC      = 3'd3;
  localparam logic [2:0] ST_INDEX      = 3'd4;
  localparam logic [2:0] ST_CRC        = 3'd5;
  localparam logic [2:0] ST_SHORT_BODY = 3'd6;
  localparam logic [2:0] ST_NEG_ROWS   = 3'd7;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_OFFSET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES    = 2'd2;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  // header bytes 0..3, lowest byte first
  localparam logic [31:0] MAGIC_WORD = 32'h0143_4552;

  localparam logic [4:0] HB_INDEX_START = 5'd4;
  localparam logic [4:0] HB_ROWS_START  = 5'd12;
  localparam logic [4:0] HB_ROWS_END    = 5'd20;
  localparam logic [4:0] HB_CRC_START   = 5'd28;
  localparam logic [4:0] HB_LAST        = 5'd31;
  localparam int HDR_BYTES = 32;
  localparam int PAD_ALIGN = 8;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int t = 0; t < 8; t++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/record_header_walker.sv]
`default_nettype none

// record header walker
// in_*: one file byte per item from the first header on; in_tuser set marks
// the end of the stream (that item carries no byte). out_*: result items,
// out_tlast set on the last result caused by an input item. cfg_*: register
// writes, taken at any edge with cfg_we high; the user must write only while
// the block is idle (not enforced by the block). Each byte is registered at
// the input, decoded combinationally and its results go into a two-entry
// output buffer. One item per cycle is accepted while the receiver keeps up.
// The row-count by row-size product runs in a two-stage registered side path
// that settles during the header's trailing bytes; the final header byte
// waits only if that path was disturbed (e.g. a row_bytes write mid-header).
// A header whose ok result is followed by done takes two buffer slots, and
// when the receiver stalls the buffer fills and in_tready drops.
// Reset: header phase, record 0, offsets zero, row_bytes 1, record_count 0.
// After any error or done the block drops every further item until reset.

module record_header_walker #(
  parameter int OFFSET_WIDTH = 48,
  parameter int RECORD_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,  // data_byte
  input  wire logic [0:0]                          in_tuser,  // end_of_stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // status, record_number, header_offset, body_offset, row_count,
  // cumulative_rows, stored_value, crc_stored, crc_actual, zero fill
  output logic [((291+2*OFFSET_WIDTH+7)/8)*8-1:0]  out_tdata,
  output logic                                     out_tlast, // last_result
  input  wire logic                                cfg_we,
  input  wire logic [rhw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [OFFSET_WIDTH-1:0]             cfg_data
);

  localparam int OW      = OFFSET_WIDTH;
  localparam int RC_W    = (RECORD_WIDTH < 32) ? RECORD_WIDTH : 32;
  localparam int FLD_W   = 291 + 2 * OW;
  localparam int TDATA_W = ((FLD_W + 7) / 8) * 8;
  localparam int PAD_W   = TDATA_W - FLD_W;
  localparam int PROD_W  = 63 + 16;
  localparam logic [OW-1:0] OMAX = '1;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_eos_r;

  // walker state
  rhw_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]      hbi_r, hbi_nxt;
  logic [31:0]     crc_r, crc_nxt;
  logic            magic_ok_r, magic_ok_nxt;
  logic [63:0]     index_r, index_nxt;
  logic [63:0]     rows_r, rows_nxt;
  logic [31:0]     crcf_r, crcf_nxt;
  logic [OW-1:0]   cur_r, cur_nxt;
  logic [OW-1:0]   hs_r, hs_nxt;
  logic [OW-1:0]   skip_r, skip_nxt;
  logic [RC_W-1:0] rc_r, rc_nxt;
  logic [63:0]     row_total_r, row_total_nxt;
  logic [31:0]     record_count_r, record_count_nxt;
  logic [15:0]     row_bytes_r, row_bytes_nxt;

  // body length side path
  logic [PROD_W-1:0] prod_r;
  logic [OW-1:0]     pad_r, pad_nxt;
  logic [OW-1:0]     body_off_r, body_off_nxt;
  logic [OW-1:0]     room_r;
  logic [1:0]        pipe_cnt_r, pipe_cnt_nxt;
  logic [OW-1:0]     len;
  logic [OW:0]       hs_sum;

  // decode
  rhw_pkg::event_t ev;
  logic            hb0, all_done, last_hdr, wait_pipe, fire;
  logic [OW-1:0]   hs_eff, cur_inc, end_cs, skip_new;
  logic [OW:0]     sum_cs;
  logic [31:0]     crc_full, crc_act;
  logic [RC_W-1:0] rc_inc;
  logic            done_after, skip_zero;
  logic [63:0]     row_total_add;
  logic [1:0]      push_n, free_n;

  // result fields
  logic [2:0]    a_status;
  logic [31:0]   a_rec;
  logic [OW-1:0] a_hoff, a_boff;
  logic [63:0]   a_rowc, a_cum, a_stored;
  logic [31:0]   a_crcs, a_crca;
  logic          a_last;
  logic [TDATA_W:0] item_a, item_b, q_item;

  assign hb0       = (phase_r == rhw_pkg::PH_HEADER) && (hbi_r == 5'd0);
  assign all_done  = ({{(32-RC_W){1'b0}}, rc_r} >= record_count_r);
  assign last_hdr  = (phase_r == rhw_pkg::PH_HEADER) && (hbi_r == rhw_pkg::HB_LAST);
  assign hs_eff    = hb0 ? cur_r : hs_r;
  assign cur_inc   = (cur_r == OMAX) ? cur_r : cur_r + 1'b1;
  assign sum_cs    = {1'b0, cur_r} + {1'b0, skip_r};
  assign end_cs    = sum_cs[OW] ? OMAX : sum_cs[OW-1:0];
  assign crc_full  = {in_byte_r, crcf_r[31:8]};
  assign crc_act   = ~crc_r;
  assign skip_new  = (pad_r > room_r) ? room_r : pad_r;
  assign skip_zero = (skip_new == '0);
  assign rc_inc    = rc_r + 1'b1;
  assign done_after = ({{(32-RC_W){1'b0}}, rc_inc} >= record_count_r);
  assign row_total_add = row_total_r + rows_r;

  always_comb begin
    if (phase_r == rhw_pkg::PH_HALT) begin
      ev = rhw_pkg::EV_NONE;
    end else if (hb0 && all_done) begin
      ev = rhw_pkg::EV_DONE_HEAD;
    end else if (in_eos_r) begin
      ev = rhw_pkg::EV_EOS;
    end else if (phase_r == rhw_pkg::PH_SKIP) begin
      if (skip_r != OW'(1)) ev = rhw_pkg::EV_SKIP_BYTE;
      else if (all_done)    ev = rhw_pkg::EV_SKIP_DONE;
      else                  ev = rhw_pkg::EV_SKIP_END;
    end else if (!last_hdr) begin
      ev = rhw_pkg::EV_HDR_BYTE;
    end else if (!magic_ok_r) begin
      ev = rhw_pkg::EV_BAD_MAGIC;
    end else if (index_r != {{(64-RC_W){1'b0}}, rc_r}) begin
      ev = rhw_pkg::EV_BAD_INDEX;
    end else if (crc_act != crc_full) begin
      ev = rhw_pkg::EV_BAD_CRC;
    end else if (rows_r[63]) begin
      ev = rhw_pkg::EV_NEG_ROWS;
    end else begin
      ev = rhw_pkg::EV_OK;
    end
  end

  assign wait_pipe = last_hdr && (pipe_cnt_r != 2'd0);
  assign fire      = in_valid_r && !wait_pipe && (push_n <= free_n);
  assign in_tready = !in_valid_r || fire;

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    hbi_nxt          = hbi_r;
    crc_nxt          = crc_r;
    magic_ok_nxt     = magic_ok_r;
    index_nxt        = index_r;
    rows_nxt         = rows_r;
    crcf_nxt         = crcf_r;
    cur_nxt          = cur_r;
    hs_nxt           = hs_r;
    skip_nxt         = skip_r;
    rc_nxt           = rc_r;
    row_total_nxt    = row_total_r;
    record_count_nxt = record_count_r;
    row_bytes_nxt    = row_bytes_r;
    if (fire) begin
      unique case (ev)
        rhw_pkg::EV_NONE: begin
        end
        rhw_pkg::EV_DONE_HEAD: begin
          hs_nxt    = cur_r;
          phase_nxt = rhw_pkg::PH_HALT;
        end
        rhw_pkg::EV_SKIP_BYTE: begin
          cur_nxt  = cur_inc;
          skip_nxt = skip_r - 1'b1;
        end
        rhw_pkg::EV_SKIP_END: begin
          cur_nxt   = cur_inc;
          skip_nxt  = skip_r - 1'b1;
          phase_nxt = rhw_pkg::PH_HEADER;
        end
        rhw_pkg::EV_HDR_BYTE: begin
          if (hb0) hs_nxt = cur_r;
          cur_nxt = cur_inc;
          hbi_nxt = hbi_r + 1'b1;
          if (hbi_r < rhw_pkg::HB_CRC_START) crc_nxt = rhw_pkg::crc32_byte(crc_r, in_byte_r);
          priority if (hbi_r < rhw_pkg::HB_INDEX_START) begin
            if (in_byte_r != rhw_pkg::MAGIC_WORD[8*hbi_r[1:0] +: 8]) magic_ok_nxt = 1'b0;
          end else if (hbi_r < rhw_pkg::HB_ROWS_START) begin
            index_nxt = {in_byte_r, index_r[63:8]};
          end else if (hbi_r < rhw_pkg::HB_ROWS_END) begin
            rows_nxt = {in_byte_r, rows_r[63:8]};
          end else if (hbi_r >= rhw_pkg::HB_CRC_START) begin
            crcf_nxt = {in_byte_r, crcf_r[31:8]};
          end else begin
          end
        end
        rhw_pkg::EV_OK: begin
          cur_nxt       = cur_inc;
          hbi_nxt       = 5'd0;
          crc_nxt       = rhw_pkg::CRC_INIT;
          magic_ok_nxt  = 1'b1;
          row_total_nxt = row_total_add;
          skip_nxt      = skip_new;
          rc_nxt        = rc_inc;
          if (!skip_zero)     phase_nxt = rhw_pkg::PH_SKIP;
          else if (done_after) phase_nxt = rhw_pkg::PH_HALT;
          else                phase_nxt = rhw_pkg::PH_HEADER;
        end
        default: begin
          phase_nxt = rhw_pkg::PH_HALT;
        end
      endcase
    end
    if (cfg_we) begin
      unique case (cfg_index)
        rhw_pkg::CFG_START_OFFSET: begin
          cur_nxt = cfg_data;
          hs_nxt  = cfg_data;
        end
        rhw_pkg::CFG_RECORD_COUNT: record_count_nxt = cfg_data[31:0];
        rhw_pkg::CFG_ROW_BYTES:    row_bytes_nxt = cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // results
  always_comb begin
    a_status = rhw_pkg::ST_OK;
    a_rec    = 32'(rc_r);
    a_hoff   = hs_r;
    a_boff   = '0;
    a_rowc   = '0;
    a_cum    = '0;
    a_stored = '0;
    a_crcs   = '0;
    a_crca   = '0;
    a_last   = 1'b1;
    push_n   = 2'd1;
    unique case (ev)
      rhw_pkg::EV_NONE, rhw_pkg::EV_SKIP_BYTE, rhw_pkg::EV_SKIP_END,
      rhw_pkg::EV_HDR_BYTE: begin
        push_n = 2'd0;
      end
      rhw_pkg::EV_DONE_HEAD: begin
        a_status = rhw_pkg::ST_DONE;
        a_hoff   = cur_r;
        a_cum    = row_total_r;
      end
      rhw_pkg::EV_SKIP_DONE: begin
        a_status = rhw_pkg::ST_DONE;
        a_hoff   = cur_inc;
        a_cum    = row_total_r;
      end
      rhw_pkg::EV_EOS: begin
        if (phase_r == rhw_pkg::PH_HEADER) begin
          a_status = rhw_pkg::ST_SHORT_HDR;
          a_hoff   = hs_eff;
          a_stored = 64'(hbi_r);
        end else if (all_done) begin
          a_status = rhw_pkg::ST_SHORT_BODY;
          a_rec    = 32'(rc_r - 1'b1);
          a_hoff   = end_cs;
          a_stored = 64'(cur_r);
        end else begin
          a_status = rhw_pkg::ST_SHORT_HDR;
          a_hoff   = end_cs;
        end
      end
      rhw_pkg::EV_BAD_MAGIC: begin
        a_status = rhw_pkg::ST_MAGIC;
      end
      rhw_pkg::EV_BAD_INDEX: begin
        a_status = rhw_pkg::ST_INDEX;
        a_stored = index_r;
      end
      rhw_pkg::EV_BAD_CRC: begin
        a_status = rhw_pkg::ST_CRC;
        a_crcs   = crc_full;
        a_crca   = crc_act;
      end
      rhw_pkg::EV_NEG_ROWS: begin
        a_status = rhw_pkg::ST_NEG_ROWS;
        a_boff   = body_off_r;
        a_rowc   = rows_r;
      end
      rhw_pkg::EV_OK: begin
        a_boff = body_off_r;
        a_rowc = rows_r;
        a_cum  = row_total_add;
        a_crcs = crc_full;
        a_crca = crc_act;
        if (skip_zero && done_after) begin
          a_last = 1'b0;
          push_n = 2'd2;
        end
      end
      default: begin
        push_n = 2'd0;
      end
    endcase
  end

  assign item_a = {a_last, {PAD_W{1'b0}}, a_crca, a_crcs, a_stored, a_cum, a_rowc,
                   a_boff, a_hoff, a_rec, a_status};
  // done after an ok header whose body is empty and no record is left
  assign item_b = {1'b1, {PAD_W{1'b0}}, 32'd0, 32'd0, 64'd0, row_total_add, 64'd0,
                   {OW{1'b0}}, cur_inc, 32'(rc_inc), rhw_pkg::ST_DONE};

  rhw_out_queue #(
    .W(TDATA_W + 1)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_n  (fire ? push_n : 2'd0),
    .push_a  (item_a),
    .push_b  (item_b),
    .free_n  (free_n),
    .q_valid (out_tvalid),
    .q_ready (out_tready),
    .q_item  (q_item)
  );

  assign out_tdata = q_item[TDATA_W-1:0];
  assign out_tlast = q_item[TDATA_W];

  // body length side path
  assign len = (|prod_r[PROD_W-1:OW]) ? OMAX : prod_r[OW-1:0];
  assign pad_nxt = (len > OMAX - OW'(PAD_ALIGN_M1)) ? OMAX
                 : ((len + OW'(PAD_ALIGN_M1)) & ~OW'(PAD_ALIGN_M1));
  localparam int PAD_ALIGN_M1 = rhw_pkg::PAD_ALIGN - 1;
  assign hs_sum = {1'b0, hs_r} + (OW+1)'(rhw_pkg::HDR_BYTES);
  assign body_off_nxt = hs_sum[OW] ? OMAX : hs_sum[OW-1:0];

  always_comb begin
    pipe_cnt_nxt = pipe_cnt_r;
    if (cfg_we || (fire && ev == rhw_pkg::EV_HDR_BYTE && hbi_r < rhw_pkg::HB_ROWS_END)) begin
      pipe_cnt_nxt = 2'd2;
    end else if (pipe_cnt_r != 2'd0) begin
      pipe_cnt_nxt = pipe_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= {16'd0, rows_r[62:0]} * {63'd0, row_bytes_r};
    pad_r      <= pad_nxt;
    body_off_r <= body_off_nxt;
    room_r     <= ~body_off_nxt;
    if (in_tready) begin
      in_byte_r <= in_tdata;
      in_eos_r  <= in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      phase_r        <= rhw_pkg::PH_HEADER;
      hbi_r          <= 5'd0;
      crc_r          <= rhw_pkg::CRC_INIT;
      magic_ok_r     <= 1'b1;
      index_r        <= '0;
      rows_r         <= '0;
      crcf_r         <= '0;
      cur_r          <= '0;
      hs_r           <= '0;
      skip_r         <= '0;
      rc_r           <= '0;
      row_total_r    <= '0;
      record_count_r <= '0;
      row_bytes_r    <= 16'd1;
      pipe_cnt_r     <= 2'd2;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      phase_r        <= phase_nxt;
      hbi_r          <= hbi_nxt;
      crc_r          <= crc_nxt;
      magic_ok_r     <= magic_ok_nxt;
      index_r        <= index_nxt;
      rows_r         <= rows_nxt;
      crcf_r         <= crcf_nxt;
      cur_r          <= cur_nxt;
      hs_r           <= hs_nxt;
      skip_r         <= skip_nxt;
      rc_r           <= rc_nxt;
      row_total_r    <= row_total_nxt;
      record_count_r <= record_count_nxt;
      row_bytes_r    <= row_bytes_nxt;
      pipe_cnt_r     <= pipe_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[design/rhw_out_queue.sv]
`default_nettype none

module rhw_out_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [1:0]   push_n,
  input  wire logic [W-1:0] push_a,
  input  wire logic [W-1:0] push_b,
  output logic [1:0]        free_n,
  output logic              q_valid,
  input  wire logic         q_ready,
  output logic [W-1:0]      q_item
);

  logic [1:0]   cnt_r, cnt_nxt;
  logic [W-1:0] head_r, head_nxt;
  logic [W-1:0] hold_r, hold_nxt;
  logic         pop;
  logic [1:0]   cnt_after;

  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = head_r;
  assign pop       = q_valid && q_ready;
  assign cnt_after = cnt_r - {1'b0, pop};
  assign free_n    = 2'd2 - cnt_after;

  always_comb begin
    head_nxt = head_r;
    hold_nxt = hold_r;
    if (cnt_after == 2'd0) begin
      if (push_n != 2'd0) head_nxt = push_a;
      if (push_n == 2'd2) hold_nxt = push_b;
    end else begin
      if (pop) head_nxt = hold_r;
      if (push_n != 2'd0) hold_nxt = push_a;
    end
    cnt_nxt = cnt_after + push_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    hold_r <= hold_nxt;
  end

endmodule

`default_nettype wire

[verif/tb_record_header_walker.sv]
module tb_record_header_walker;
  import rhw_pkg::*;

  localparam int TDATA_W = 392;
  localparam int FIELD_BITS = 387;
  localparam logic [47:0] OFF_MAX = '1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic        last_res;
    logic [31:0] crc_act;
    logic [31:0] crc_st;
    logic [63:0] stored;
    logic [63:0] cum;
    logic [63:0] rows;
    logic [47:0] body_off;
    logic [47:0] hdr_off;
    logic [31:0] rec;
    logic [2:0]  status;
  } walk_result_t;

  typedef enum {FLAW_NONE, FLAW_MAGIC, FLAW_INDEX, FLAW_CRC} hdr_flaw_t;

  typedef enum {
    END_NONE_LEFT, END_DONE_EMPTY, END_DONE_BODY, END_EOS_HEADER, END_EOS_BODY_LAST,
    END_EOS_BODY_MID, END_HUGE_BODY, END_BAD_MAGIC, END_BAD_INDEX, END_BAD_CRC,
    END_NEG_ROWS
  } stream_end_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  // walker state as the block should hold it
  phase_t walk_phase = PH_HEADER;
  logic [4:0] hdr_pos = '0;
  logic [31:0] crc_acc = CRC_INIT;
  logic magic_good = 1'b1;
  logic [63:0] idx_word = '0;
  logic [63:0] rows_word = '0;
  logic [31:0] crc_word = '0;
  logic [47:0] cur_off = '0;
  logic [47:0] hdr_base = '0;
  logic [47:0] body_left = '0;
  logic [31:0] rec_ctr = '0;
  logic [63:0] rows_sum = '0;
  logic [47:0] cfg_start = '0;
  logic [31:0] cfg_records = '0;
  logic [15:0] cfg_row_bytes = 16'd1;

  walk_result_t pending_results[$];
  int fail_cnt = 0;
  int checked = 0;
  int fed_items = 0;
  int hold = 0;
  bit steady = 0;
  stream_end_t end_kind;

  record_header_walker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int t = 0; t < 8; t++) x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
    return x;
  endfunction

  function automatic logic [47:0] off_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = a + b;
    return s[48] ? OFF_MAX : s[47:0];
  endfunction

  function automatic walk_result_t done_summary();
    walk_result_t d;
    d = '0;
    d.status = ST_DONE;
    d.rec = rec_ctr;
    d.hdr_off = cur_off;
    d.cum = rows_sum;
    return d;
  endfunction

  task automatic close_with(walk_result_t r);
    r.last_res = 1'b1;
    pending_results.push_back(r);
    walk_phase = PH_HALT;
  endtask

  task automatic predict_walk(logic [7:0] b, logic eos);
    walk_result_t r;
    logic [31:0] crc_now;
    logic [47:0] body_at, end_at;
    logic [63:0] len, padded;
    r = '0;
    if (walk_phase == PH_HALT) return;
    if (walk_phase == PH_HEADER && hdr_pos == 0) begin
      hdr_base = cur_off;
      if (rec_ctr >= cfg_records) begin
        close_with(done_summary());
        return;
      end
    end
    if (eos) begin
      if (walk_phase == PH_HEADER) begin
        r.status = ST_SHORT_HDR;
        r.rec = rec_ctr;
        r.hdr_off = hdr_base;
        r.stored = hdr_pos;
      end else if (rec_ctr >= cfg_records) begin
        r.status = ST_SHORT_BODY;
        r.rec = rec_ctr - 1;
        r.hdr_off = off_add(cur_off, body_left);
        r.stored = cur_off;
      end else begin
        r.status = ST_SHORT_HDR;
        r.rec = rec_ctr;
        r.hdr_off = off_add(cur_off, body_left);
      end
      close_with(r);
      return;
    end
    cur_off = off_add(cur_off, 48'd1);
    if (walk_phase == PH_SKIP) begin
      body_left--;
      if (body_left != 0) return;
      if (rec_ctr >= cfg_records) close_with(done_summary());
      else walk_phase = PH_HEADER;
      return;
    end
    if (hdr_pos < HB_CRC_START) crc_acc = crc_step(crc_acc, b);
    if (hdr_pos < HB_INDEX_START) begin
      if (b != MAGIC_WORD[8*hdr_pos +: 8]) magic_good = 1'b0;
    end else if (hdr_pos < HB_ROWS_START) begin
      idx_word[8*(hdr_pos-HB_INDEX_START) +: 8] = b;
    end else if (hdr_pos < HB_ROWS_END) begin
      rows_word[8*(hdr_pos-HB_ROWS_START) +: 8] = b;
    end else if (hdr_pos >= HB_CRC_START) begin
      crc_word[8*(hdr_pos-HB_CRC_START) +: 8] = b;
    end
    if (hdr_pos < HB_LAST) begin
      hdr_pos++;
      return;
    end
    // full header in hand
    crc_now = ~crc_acc;
    body_at = off_add(hdr_base, 48'(HDR_BYTES));
    hdr_pos = '0;
    crc_acc = CRC_INIT;
    r.rec = rec_ctr;
    r.hdr_off = hdr_base;
    if (!magic_good) begin
      r.status = ST_MAGIC;
      close_with(r);
    end else if (idx_word != {32'd0, rec_ctr}) begin
      r.status = ST_INDEX;
      r.stored = idx_word;
      close_with(r);
    end else if (crc_now != crc_word) begin
      r.status = ST_CRC;
      r.crc_st = crc_word;
      r.crc_act = crc_now;
      close_with(r);
    end else if (rows_word[63]) begin
      r.status = ST_NEG_ROWS;
      r.body_off = body_at;
      r.rows = rows_word;
      close_with(r);
    end else begin
      rows_sum += rows_word;
      r.status = ST_OK;
      r.body_off = body_at;
      r.rows = rows_word;
      r.cum = rows_sum;
      r.crc_st = crc_word;
      r.crc_act = crc_now;
      if (cfg_row_bytes == 0) len = '0;
      else if (rows_word > 64'(OFF_MAX) / 64'(cfg_row_bytes)) len = 64'(OFF_MAX);
      else len = rows_word * 64'(cfg_row_bytes);
      if (len > 64'(OFF_MAX) - 64'(PAD_ALIGN - 1)) padded = 64'(OFF_MAX);
      else padded = (len + 64'(PAD_ALIGN - 1)) & ~64'(PAD_ALIGN - 1);
      end_at = off_add(body_at, padded[47:0]);
      body_left = end_at - body_at;
      rec_ctr++;
      magic_good = 1'b1;
      idx_word = '0;
      rows_word = '0;
      crc_word = '0;
      if (body_left != 0) begin
        walk_phase = PH_SKIP;
        r.last_res = 1'b1;
        pending_results.push_back(r);
      end else if (rec_ctr >= cfg_records) begin
        pending_results.push_back(r);
        close_with(done_summary());
      end else begin
        walk_phase = PH_HEADER;
        r.last_res = 1'b1;
        pending_results.push_back(r);
      end
    end
  endtask

  task automatic push_item(logic [7:0] b, logic eos);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= eos;
    do @(posedge clk); while (in_tready !== 1'b1);
    fed_items++;
    predict_walk(b, eos);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [47:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_START_OFFSET: begin
        cfg_start = val;
        cur_off = val;
        hdr_base = val;
      end
      CFG_RECORD_COUNT: cfg_records = val[31:0];
      CFG_ROW_BYTES: cfg_row_bytes = val[15:0];
      default: ;
    endcase
  endtask

  // sends the first upto bytes of a header for the next record
  task automatic send_header(logic [63:0] rows, hdr_flaw_t flaw, int upto);
    logic [7:0] hb [HDR_BYTES];
    logic [63:0] idx;
    logic [31:0] c;
    int k;
    idx = {32'd0, rec_ctr};
    if (flaw == FLAW_INDEX) idx ^= 64'd1 << $urandom_range(0, 63);
    for (int i = 0; i < 4; i++) hb[i] = MAGIC_WORD[8*i +: 8];
    for (int i = 0; i < 8; i++) begin
      hb[HB_INDEX_START + i] = idx[8*i +: 8];
      hb[HB_ROWS_START + i] = rows[8*i +: 8];
      hb[HB_ROWS_END + i] = 8'($urandom);
    end
    if (flaw == FLAW_MAGIC) begin
      k = $urandom_range(0, 3);
      hb[k] ^= 8'($urandom_range(1, 255));
    end
    c = CRC_INIT;
    for (int i = 0; i < HB_CRC_START; i++) c = crc_step(c, hb[i]);
    c = ~c;
    if (flaw == FLAW_CRC) c ^= 32'd1 << $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) hb[HB_CRC_START + i] = c[8*i +: 8];
    for (int i = 0; i < upto; i++) push_item(hb[i], 1'b0);
  endtask

  task automatic send_body(longint n);
    for (longint i = 0; i < n; i++) push_item(8'($urandom), 1'b0);
  endtask

  task automatic send_record(logic [63:0] rows);
    send_header(rows, FLAW_NONE, HDR_BYTES);
    if (walk_phase == PH_SKIP) send_body(longint'(body_left));
  endtask

  task automatic cmp_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_cnt++;
    end
  endtask

  task automatic check_result();
    walk_result_t want, got;
    got = {out_tlast, out_tdata[FIELD_BITS-1:0]};
    checked++;
    if (pending_results.size() == 0) begin
      $error("result with nothing expected, status %0d", got.status);
      fail_cnt++;
      return;
    end
    want = pending_results.pop_front();
    cmp_field("status", want.status, got.status);
    cmp_field("record_number", want.rec, got.rec);
    cmp_field("header_offset", want.hdr_off, got.hdr_off);
    cmp_field("body_offset", want.body_off, got.body_off);
    cmp_field("row_count", want.rows, got.rows);
    cmp_field("cumulative_rows", want.cum, got.cum);
    cmp_field("stored_value", want.stored, got.stored);
    cmp_field("crc_stored", want.crc_st, got.crc_st);
    cmp_field("crc_actual", want.crc_act, got.crc_act);
    cmp_field("last_result", want.last_res, got.last_res);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) check_result();
    if (hold > 0) begin
      hold--;
      out_tready <= 1'b0;
    end else begin
      hold = pick_gap();
      out_tready <= (hold == 0);
    end
  end

  task automatic test_register_setup();
    write_reg(CFG_SPARE, {$urandom, $urandom});
    write_reg(CFG_RECORD_COUNT, 48'hFFFF_FFFF);
    write_reg(CFG_ROW_BYTES, 48'd1);
    write_reg(CFG_START_OFFSET, '0);
  endtask

  task automatic test_body_padding();
    send_record(64'd0);
    send_record(64'd1);
    send_record(64'd8);
    send_record(64'd9);
    write_reg(CFG_ROW_BYTES, 48'hFFFF);
    send_record(64'd0);
    write_reg(CFG_ROW_BYTES, 48'd0);
    send_record(64'd5);
  endtask

  task automatic test_offset_saturation();
    write_reg(CFG_START_OFFSET, OFF_MAX - 48'd40);
    write_reg(CFG_ROW_BYTES, 48'd3);
    send_record(64'd5);
    send_record(64'd2);
    write_reg(CFG_START_OFFSET, OFF_MAX);
    send_record(64'd1);
    write_reg(CFG_START_OFFSET, {1'b0, 15'($urandom), $urandom});
    write_reg(CFG_ROW_BYTES, 48'd1);
  endtask

  task automatic test_row_total_wrap();
    write_reg(CFG_ROW_BYTES, 48'd0);
    send_record(64'h7FFF_FFFF_FFFF_FFFF);
    send_record(64'h7FFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_random_walk();
    int walked;
    int r;
    logic [63:0] rows;
    walked = 0;
    while (fed_items < 1050 || walked < 36) begin
      steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        r = $urandom_range(0, 19);
        if (r < 2) write_reg(CFG_ROW_BYTES, 48'd0);
        else if (r == 2) write_reg(CFG_ROW_BYTES, 48'hFFFF);
        else write_reg(CFG_ROW_BYTES, 48'($urandom_range(1, 16)));
      end else if (r == 1) begin
        write_reg(CFG_START_OFFSET, {1'b0, 15'($urandom), $urandom});
      end else if (r == 2) begin
        write_reg(CFG_RECORD_COUNT, 48'($urandom_range(rec_ctr + 1000, 32'hFFFF_FFFF)));
      end
      if (cfg_row_bytes == 0) rows = {1'b0, 31'($urandom), $urandom};
      else if (cfg_row_bytes > 16) rows = '0;
      else rows = 64'($urandom_range(0, 3));
      send_record(rows);
      walked++;
    end
    steady = 0;
  endtask

  task automatic test_stream_end();
    int n;
    end_kind = stream_end_t'($urandom_range(0, int'(END_NEG_ROWS)));
    case (end_kind)
      END_NONE_LEFT: begin
        write_reg(CFG_RECORD_COUNT, 48'(rec_ctr));
        push_item(8'($urandom), 1'($urandom));
      end
      END_DONE_EMPTY: begin
        write_reg(CFG_RECORD_COUNT, 48'(rec_ctr + 1));
        write_reg(CFG_ROW_BYTES, 48'($urandom_range(0, 8)));
        send_record(64'd0);
      end
      END_DONE_BODY: begin
        write_reg(CFG_RECORD_COUNT, 48'(rec_ctr + 1));
        write_reg(CFG_ROW_BYTES, 48'($urandom_range(1, 8)));
        send_record(64'($urandom_range(1, 6)));
      end
      END_EOS_HEADER: begin
        send_header(64'd1, FLAW_NONE, $urandom_range(0, HDR_BYTES - 1));
        push_item(8'($urandom), 1'b1);
      end
      END_EOS_BODY_LAST, END_EOS_BODY_MID: begin
        if (end_kind == END_EOS_BODY_LAST) write_reg(CFG_RECORD_COUNT, 48'(rec_ctr + 1));
        write_reg(CFG_ROW_BYTES, 48'd4);
        send_header(64'($urandom_range(1, 6)), FLAW_NONE, HDR_BYTES);
        n = $urandom_range(0, int'(body_left) - 1);
        send_body(n);
        push_item(8'($urandom), 1'b1);
      end
      END_HUGE_BODY: begin
        if ($urandom_range(0, 1)) write_reg(CFG_RECORD_COUNT, 48'(rec_ctr + 1));
        write_reg(CFG_ROW_BYTES, 48'hFFFF);
        send_header({1'b0, 31'($urandom) | 31'h100, $urandom}, FLAW_NONE, HDR_BYTES);
        send_body($urandom_range(0, 20));
        push_item(8'($urandom), 1'b1);
      end
      END_BAD_MAGIC: send_header(64'd1, FLAW_MAGIC, HDR_BYTES);
      END_BAD_INDEX: send_header(64'd1, FLAW_INDEX, HDR_BYTES);
      END_BAD_CRC: send_header(64'd1, FLAW_CRC, HDR_BYTES);
      END_NEG_ROWS: send_header({1'b1, 31'($urandom), $urandom}, FLAW_NONE, HDR_BYTES);
      default: ;
    endcase
  endtask

  task automatic test_after_halt();
    repeat (16) push_item(8'($urandom), 1'($urandom));
  endtask

  initial begin
    int waited;
    waited = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_register_setup();
    test_body_padding();
    test_offset_saturation();
    test_row_total_wrap();
    test_random_walk();
    test_stream_end();
    test_after_halt();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_cnt++;
    end
    $display("walked %0d records over %0d items, %0d results checked",
             rec_ctr, fed_items, checked);
    $display("stream closed by %s, then ignored items sent", end_kind.name());
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
